[sv/hma_pkg.sv]
// Shared widths and types for the triangle mesh area accumulator.
package hma_pkg;

	localparam int COORD_BITS = 32;
	localparam int IN_W       = 32;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W + 2;
	localparam int EDGE_W     = SQ_W / 2;
	localparam int FAC_W      = EDGE_W + 2;
	localparam int MB_W       = FAC_W;
	localparam int PROD_W     = 4 * FAC_W;
	localparam int ROOT_W     = PROD_W / 2;
	localparam int SQ_SHIFT   = PROD_W - SQ_W;
	localparam int AREA_SHIFT = 18;
	localparam int AREA_W     = 63;
	localparam int CNT_W      = $clog2(ROOT_W + 1);
	localparam int MCNT_W     = $clog2(MB_W + 1);
	localparam int IN_DATA_W  = 9 * IN_W;
	localparam int OUT_DATA_W = ((2 * AREA_W + 7) / 8) * 8;

	typedef logic [DIFF_W-1:0] diff_t;

	// d[edge][axis]: edge 0 is B-C, 1 is A-C, 2 is A-B
	typedef struct packed {
		diff_t [2:0][2:0] d;
		logic             last;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
	} sq_req_t;

endpackage

[sv/hma_front.sv]
// Front end: sign-extends the vertices and forms absolute coordinate differences.
module hma_front import hma_pkg::*; (
	input  logic [IN_DATA_W-1:0] in_data,
	input  logic                 in_last,
	output item_t                item
);

	logic signed [DIFF_W-1:0] crd [9];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			crd[i] = DIFF_W'($signed(in_data[i*IN_W +: COORD_BITS]));
		end
	end

	function automatic diff_t absdiff(input logic signed [DIFF_W-1:0] p,
		input logic signed [DIFF_W-1:0] q);
		logic signed [DIFF_W-1:0] d;
		d = p - q;
		return d[DIFF_W-1] ? diff_t'(-d) : diff_t'(d);
	endfunction

	always_comb begin
		item.last = in_last;
		for (int k = 0; k < 3; k++) begin
			item.d[0][k] = absdiff(crd[3 + k], crd[6 + k]);
			item.d[1][k] = absdiff(crd[k], crd[6 + k]);
			item.d[2][k] = absdiff(crd[k], crd[3 + k]);
		end
	end

endmodule

[sv/hma_fifo.sv]
// Two-entry queue between the front end and the arithmetic back end.
module hma_fifo import hma_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t pop_item
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[sv/hma_sqrt.sv]
// Iterative integer square root, one result bit per cycle from the top.
module hma_sqrt import hma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  sq_req_t           req,
	input  logic [PROD_W-1:0] radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [PROD_W-1:0] x_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [ROOT_W+1:0] rem2;
	logic [ROOT_W+1:0] trial;
	logic              ge;

	assign rem2  = {rem_q[ROOT_W-1:0], x_q[PROD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign ge    = (rem2 >= trial);
	assign done  = busy_q && (cnt_q == CNT_W'(1));
	assign root  = {root_q[ROOT_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? (rem2 - trial) : rem2;
			root_q <= root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[sv/hma_back.sv]
// Back end: edge lengths, Heron product, area root and saturating mesh total.
module hma_back import hma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [AREA_W-1:0] out_area,
	output logic [AREA_W-1:0] out_total,
	output logic              out_last
);

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_ESQ, S_FAC, S_PM, S_ASQ, S_OUT
	} state_t;

	state_t              state_q;
	item_t               item_q;
	logic [EDGE_W-1:0]   edge_q [3];
	logic [FAC_W-1:0]    fac_q [3];
	logic [1:0]          ei_q;
	logic [1:0]          k_q;
	logic [1:0]          pi_q;
	logic [MCNT_W-1:0]   mcnt_q;
	logic [PROD_W-1:0]   ma_q;
	logic [MB_W-1:0]     mb_q;
	logic [PROD_W-1:0]   acc_q;
	logic [AREA_W-1:0]   sum_q;
	logic [PROD_W-1:0]   acc_next;
	logic signed [FAC_W:0] xa, xb, xc, f1, f2, f3, per;
	logic                pos;
	sq_req_t             sq_req;
	logic [PROD_W-1:0]   sq_rad;
	logic                sq_done;
	logic [ROOT_W-1:0]   sq_root;
	logic [AREA_W-1:0]   area_fin;
	logic [AREA_W:0]     total_raw;
	logic [AREA_W-1:0]   total_sat;
	logic                finish;

	hma_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (sq_req),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign acc_next = acc_q + (mb_q[0] ? ma_q : '0);

	assign xa  = $signed({{(FAC_W+1-EDGE_W){1'b0}}, edge_q[0]});
	assign xb  = $signed({{(FAC_W+1-EDGE_W){1'b0}}, edge_q[1]});
	assign xc  = $signed({{(FAC_W+1-EDGE_W){1'b0}}, edge_q[2]});
	assign f1  = xb + xc - xa;
	assign f2  = xa + xc - xb;
	assign f3  = xa + xb - xc;
	assign per = xa + xb + xc;
	assign pos = (f1 > 0) && (f2 > 0) && (f3 > 0);

	always_comb begin
		sq_req.start = 1'b0;
		sq_req.steps = CNT_W'(SQ_W / 2);
		sq_rad       = acc_next << SQ_SHIFT;
		if (mcnt_q == MCNT_W'(1)) begin
			if (state_q == S_SQ && k_q == 2'd2) begin
				sq_req.start = 1'b1;
			end else if (state_q == S_PM && pi_q == 2'd2) begin
				sq_req.start = 1'b1;
				sq_req.steps = CNT_W'(ROOT_W);
				sq_rad       = acc_next;
			end
		end
	end

	assign area_fin  = (state_q == S_ASQ) ? AREA_W'(sq_root[ROOT_W-1:AREA_SHIFT]) : '0;
	assign total_raw = {1'b0, sum_q} + {1'b0, area_fin};
	assign total_sat = total_raw[AREA_W] ? {AREA_W{1'b1}} : total_raw[AREA_W-1:0];
	assign finish    = (state_q == S_FAC && !pos) || (state_q == S_ASQ && sq_done);
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			sum_q     <= '0;
			ei_q      <= '0;
			k_q       <= '0;
			pi_q      <= '0;
			mcnt_q    <= '0;
		end else begin
			if (finish) begin
				out_area  <= area_fin;
				out_total <= total_sat;
				out_last  <= item_q.last;
				out_valid <= 1'b1;
				sum_q     <= item_q.last ? '0 : total_sat;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						ei_q   <= 2'd0;
						k_q    <= 2'd0;
						acc_q  <= '0;
						ma_q   <= PROD_W'(q_item.d[0][0]);
						mb_q   <= MB_W'(q_item.d[0][0]);
						mcnt_q <= MCNT_W'(MB_W);
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					acc_q  <= acc_next;
					ma_q   <= ma_q << 1;
					mb_q   <= mb_q >> 1;
					mcnt_q <= mcnt_q - MCNT_W'(1);
					if (mcnt_q == MCNT_W'(1)) begin
						if (k_q == 2'd2) begin
							state_q <= S_ESQ;
						end else begin
							// next axis of the same edge
							k_q    <= k_q + 2'd1;
							ma_q   <= PROD_W'(item_q.d[ei_q][k_q + 2'd1]);
							mb_q   <= MB_W'(item_q.d[ei_q][k_q + 2'd1]);
							mcnt_q <= MCNT_W'(MB_W);
						end
					end
				end
				S_ESQ: begin
					if (sq_done) begin
						edge_q[ei_q] <= sq_root[EDGE_W-1:0];
						if (ei_q == 2'd2) begin
							state_q <= S_FAC;
						end else begin
							ei_q   <= ei_q + 2'd1;
							k_q    <= 2'd0;
							acc_q  <= '0;
							ma_q   <= PROD_W'(item_q.d[ei_q + 2'd1][0]);
							mb_q   <= MB_W'(item_q.d[ei_q + 2'd1][0]);
							mcnt_q <= MCNT_W'(MB_W);
							state_q <= S_SQ;
						end
					end
				end
				S_FAC: begin
					if (pos) begin
						fac_q[0] <= f1[FAC_W-1:0];
						fac_q[1] <= f2[FAC_W-1:0];
						fac_q[2] <= f3[FAC_W-1:0];
						acc_q    <= '0;
						ma_q     <= PROD_W'(per[FAC_W-1:0]);
						mb_q     <= f1[FAC_W-1:0];
						mcnt_q   <= MCNT_W'(MB_W);
						pi_q     <= 2'd0;
						state_q  <= S_PM;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_PM: begin
					acc_q  <= acc_next;
					ma_q   <= ma_q << 1;
					mb_q   <= mb_q >> 1;
					mcnt_q <= mcnt_q - MCNT_W'(1);
					if (mcnt_q == MCNT_W'(1)) begin
						if (pi_q == 2'd2) begin
							state_q <= S_ASQ;
						end else begin
							// fold the product so far against the next factor
							pi_q   <= pi_q + 2'd1;
							acc_q  <= '0;
							ma_q   <= acc_next;
							mb_q   <= fac_q[pi_q + 2'd1];
							mcnt_q <= MCNT_W'(MB_W);
						end
					end
				end
				S_ASQ: begin
					if (sq_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/triangle_mesh_area_accumulator_unit.sv]
// Top level of the triangle mesh area accumulator.
// One triangle is taken per transaction on the s_ side and gives one result on the m_ side.
// Work on a triangle is set by the one shared shift-add multiplier
// (one bit of the multiplier a cycle) and the square root unit (one root bit a cycle);
// a two-entry queue lets two further triangles be taken meanwhile.
// The mesh total saturates at 2^63-1 and is cleared after the result that carries tlast.
module triangle_mesh_area_accumulator_unit import hma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // ax, ay, az, bx, by_coord, bz, cx, cy, cz
	input  logic                  s_tlast,  // last_triangle
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // triangle_area, total_area, zero pad
	output logic                  m_tlast   // mesh_done
);

	item_t             fr_item;
	item_t             q_item;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic [AREA_W-1:0] area;
	logic [AREA_W-1:0] total;

	hma_front u_front (
		.in_data (s_tdata),
		.in_last (s_tlast),
		.item    (fr_item)
	);

	assign s_tready = !q_full;

	hma_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && !q_full),
		.push_item (fr_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_item  (q_item)
	);

	hma_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_area  (area),
		.out_total (total),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(OUT_DATA_W - 2*AREA_W){1'b0}}, total, area};

endmodule

[sv/hma_checker.sv]
// Port-level checks for the triangle mesh area accumulator.
module hma_checker import hma_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_total_ge_area: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2*AREA_W-1:AREA_W] >= m_tdata[AREA_W-1:0])
		else $error("total below triangle area");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:2*AREA_W] == '0)
		else $error("padding bits set");

endmodule

bind triangle_mesh_area_accumulator_unit hma_checker u_hma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
